// File: hdl/hbw_pkg.sv
`timescale 1ns / 1ps

package hbw_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W = 4;
	localparam int CMD_W  = 3;
	localparam int MS_W   = 16;
	localparam int AGE_W  = 18;
	localparam int WIDE_W = 20;
	localparam int DIFF_W = 19;
	localparam int DL_W   = 17;
	localparam int KIND_W = 3;
	localparam int ENT_W  = MS_W + AGE_W;
	localparam int IN_W   = 56;
	localparam int OUT_W  = 24;

	localparam logic signed [WIDE_W-1:0] AGE_MAX = 20'sd131071;
	localparam logic signed [WIDE_W-1:0] AGE_MIN = -20'sd131072;
	localparam logic signed [DIFF_W-1:0] DL_NONE = 19'sd131071;

	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REG   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UNREG = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ANS   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PREQ  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RST   = 3'd5;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_REG   = 3'd1;
	localparam logic [2:0] OP_UNREG = 3'd2;
	localparam logic [2:0] OP_ANS   = 3'd3;
	localparam logic [2:0] OP_PREQ  = 3'd4;
	localparam logic [2:0] OP_RST   = 3'd5;
	localparam logic [2:0] OP_NOP   = 3'd6;

	localparam logic [KIND_W-1:0] K_DONE        = 3'd0;
	localparam logic [KIND_W-1:0] K_HB_REQ      = 3'd1;
	localparam logic [KIND_W-1:0] K_FATAL_HB    = 3'd2;
	localparam logic [KIND_W-1:0] K_FATAL_UNREG = 3'd3;
	localparam logic [KIND_W-1:0] K_QUITTING    = 3'd4;
	localparam logic [KIND_W-1:0] K_UNKNOWN     = 3'd5;
	localparam logic [KIND_W-1:0] K_FULL        = 3'd6;
	localparam logic [KIND_W-1:0] K_HALTED      = 3'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic [SLOT_W-1:0] slot;
		logic [MS_W-1:0]   elapsed;
		logic [MS_W-1:0]   tmo;
		logic [MS_W-1:0]   delay;
	} cmd_t;

	// one command's results: request mask in slot order, then the final item
	typedef struct packed {
		logic [SLOTS-1:0]  mask;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [DL_W-1:0]   deadline;
	} bat_t;

	function automatic logic signed [AGE_W-1:0] sat_age(input logic signed [WIDE_W-1:0] v);
		logic signed [AGE_W-1:0] r;
		if (v > AGE_MAX) begin
			r = AGE_MAX[AGE_W-1:0];
		end else if (v < AGE_MIN) begin
			r = AGE_MIN[AGE_W-1:0];
		end else begin
			r = v[AGE_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/hbw_ram.sv
`timescale 1ns / 1ps

module hbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/hbw_front.sv
`timescale 1ns / 1ps

module hbw_front
	import hbw_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	output logic            q_valid,
	input  logic            q_ready,
	output cmd_t            q_cmd
);

	cmd_t       dec;
	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		dec.slot    = s_tdata[6:3];
		dec.elapsed = s_tdata[22:7];
		dec.tmo     = s_tdata[38:23];
		dec.delay   = s_tdata[54:39];
		case (s_tdata[2:0])
			CMD_TICK:  dec.op = OP_TICK;
			CMD_REG:   dec.op = OP_REG;
			CMD_UNREG: dec.op = OP_UNREG;
			CMD_ANS:   dec.op = OP_ANS;
			CMD_PREQ:  dec.op = OP_PREQ;
			CMD_RST:   dec.op = OP_RST;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = ent_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("queue count did not drop on pop");
`endif

endmodule

// File: hdl/hbw_exec.sv
`timescale 1ns / 1ps

module hbw_exec
	import hbw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cmd_t q_cmd,
	output logic bat_valid,
	input  logic bat_ready,
	output bat_t bat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]              state_q;
	logic [SLOTS-1:0]        valid_q, ans_q, quit_q;
	logic                    halted_q;
	logic                    tick_q, rst_q, stop_q;
	logic [IDX_W-1:0]        slot_q;
	logic [MS_W-1:0]         e_q;
	logic [IDX_W:0]          rd_cnt_q;
	logic                    v_s1, last_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    v_s2, last_s2, live_s2;
	logic signed [DIFF_W-1:0] d_s2;
	logic [SLOTS-1:0]        mask_q;
	logic [KIND_W-1:0]       fkind_q;
	logic [SLOT_W-1:0]       fslot_q;
	logic signed [DIFF_W-1:0] best_q;

	// command decode
	logic                    take;
	logic [IDX_W-1:0]        cidx;
	logic                    live;
	logic                    any_free;
	logic [IDX_W-1:0]        free_idx;
	logic signed [WIDE_W-1:0] ce_x, cd_x;

	// table scan, stage 1
	logic [ENT_W-1:0]        rdata;
	logic [MS_W-1:0]         tmo1;
	logic signed [AGE_W-1:0] age1, a1, a2, age_new;
	logic signed [WIDE_W-1:0] age_x, e_x, tmo_x, a1_x;
	logic                    live1, upd, hb, fatal;
	logic signed [DIFF_W-1:0] d_next;

	// RAM write port
	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic [ENT_W-1:0]        wdata;

	assign q_ready = (state_q == ST_IDLE);
	assign take    = q_valid && q_ready;
	assign cidx    = IDX_W'(q_cmd.slot);
	assign live    = (int'(q_cmd.slot) < SLOTS) && valid_q[cidx];
	assign ce_x    = {{(WIDE_W-MS_W){1'b0}}, q_cmd.elapsed};
	assign cd_x    = {{(WIDE_W-MS_W){1'b0}}, q_cmd.delay};

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign tmo1  = rdata[ENT_W-1:AGE_W];
	assign age1  = rdata[AGE_W-1:0];
	assign age_x = {{(WIDE_W-AGE_W){age1[AGE_W-1]}}, age1};
	assign e_x   = {{(WIDE_W-MS_W){1'b0}}, e_q};
	assign tmo_x = {{(WIDE_W-MS_W){1'b0}}, tmo1};
	assign a1    = sat_age(age_x + e_x);
	assign a1_x  = {{(WIDE_W-AGE_W){a1[AGE_W-1]}}, a1};
	assign a2    = sat_age(a1_x - tmo_x);
	assign live1 = v_s1 && valid_q[idx_s1];

	always_comb begin
		age_new = age1;
		upd     = 1'b0;
		hb      = 1'b0;
		fatal   = 1'b0;
		if (live1 && tick_q && !stop_q) begin
			upd     = 1'b1;
			age_new = a1;
			if (a1_x >= tmo_x) begin
				if (ans_q[idx_s1]) begin
					age_new = a2;
					hb      = 1'b1;
				end else begin
					fatal = 1'b1;
				end
			end
		end
		if (live1 && rst_q && (idx_s1 == slot_q)) begin
			upd     = 1'b1;
			age_new = sat_age(age_x - e_x);
		end
		d_next = {{(DIFF_W-MS_W){1'b0}}, tmo1} - {age_new[AGE_W-1], age_new};
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = {tmo1, age_new};
		if (state_q == ST_SCAN) begin
			we = upd;
		end else if (take && !halted_q) begin
			if (q_cmd.op == OP_REG && any_free) begin
				we    = 1'b1;
				waddr = free_idx;
				wdata = {q_cmd.tmo, sat_age(-(cd_x + ce_x))};
			end else if (q_cmd.op == OP_PREQ && live && !quit_q[cidx]) begin
				we    = 1'b1;
				waddr = cidx;
				wdata = {q_cmd.tmo, sat_age(-ce_x)};
			end
		end
	end

	hbw_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			ans_q    <= '0;
			quit_q   <= '0;
			halted_q <= 1'b0;
			tick_q   <= 1'b0;
			rst_q    <= 1'b0;
			stop_q   <= 1'b0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					if (take) begin
						state_q  <= ST_SCAN;
						rd_cnt_q <= '0;
						stop_q   <= 1'b0;
						tick_q   <= 1'b0;
						rst_q    <= 1'b0;
						if (!halted_q) begin
							case (q_cmd.op)
								OP_TICK: begin
									tick_q <= 1'b1;
								end
								OP_REG: begin
									if (any_free) begin
										valid_q[free_idx] <= 1'b1;
										ans_q[free_idx]   <= 1'b0;
										quit_q[free_idx]  <= 1'b0;
									end
								end
								OP_UNREG: begin
									if (live) begin
										valid_q[cidx] <= 1'b0;
										ans_q[cidx]   <= 1'b0;
										quit_q[cidx]  <= 1'b0;
									end
								end
								OP_ANS: begin
									if (live && !quit_q[cidx]) begin
										ans_q[cidx] <= 1'b1;
									end
								end
								OP_PREQ: begin
									if (live && !quit_q[cidx]) begin
										ans_q[cidx]  <= 1'b0;
										quit_q[cidx] <= 1'b1;
									end
								end
								OP_RST: begin
									rst_q <= live && !quit_q[cidx];
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (int'(rd_cnt_q) < SLOTS) begin
						v_s1     <= 1'b1;
						last_s1  <= (int'(rd_cnt_q) == SLOTS - 1);
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (hb) begin
						ans_q[idx_s1] <= 1'b0;
					end
					if (fatal) begin
						halted_q <= 1'b1;
						stop_q   <= 1'b1;
					end
					if (v_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					v_s1 <= 1'b0;
					if (bat_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_cnt_q[IDX_W-1:0];
		live_s2 <= live1;
		d_s2    <= d_next;
		if (take) begin
			slot_q <= cidx;
			e_q    <= q_cmd.elapsed;
			mask_q <= '0;
			best_q <= DL_NONE;
			if (halted_q) begin
				fkind_q <= K_HALTED;
				fslot_q <= '0;
			end else begin
				case (q_cmd.op)
					OP_TICK: begin
						fkind_q <= K_DONE;
						fslot_q <= '0;
					end
					OP_REG: begin
						fkind_q <= any_free ? K_HB_REQ : K_FULL;
						fslot_q <= any_free ? SLOT_W'(free_idx) : '0;
					end
					OP_UNREG: begin
						fkind_q <= live ? K_DONE : K_UNKNOWN;
						fslot_q <= q_cmd.slot;
					end
					OP_ANS, OP_RST: begin
						fkind_q <= !live ? K_UNKNOWN : (quit_q[cidx] ? K_QUITTING : K_DONE);
						fslot_q <= q_cmd.slot;
					end
					OP_PREQ: begin
						fkind_q <= (live && quit_q[cidx]) ? K_QUITTING : K_DONE;
						fslot_q <= q_cmd.slot;
					end
					default: begin
						fkind_q <= K_DONE;
						fslot_q <= '0;
					end
				endcase
			end
		end else if (state_q == ST_SCAN) begin
			if (hb) begin
				mask_q[idx_s1] <= 1'b1;
			end
			if (fatal) begin
				fkind_q <= quit_q[idx_s1] ? K_FATAL_UNREG : K_FATAL_HB;
				fslot_q <= SLOT_W'(idx_s1);
			end
			if (v_s2 && live_s2 && (d_s2 < best_q)) begin
				best_q <= d_s2;
			end
		end
	end

	assign bat_valid    = (state_q == ST_DONE);
	assign bat.mask     = mask_q;
	assign bat.kind     = fkind_q;
	assign bat.slot     = fslot_q;
	assign bat.deadline = best_q[DIFF_W-1] ? '0 : best_q[DL_W-1:0];

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> halted_q)
		else $error("scan stopped without halt");
	a_flags_live: assert property (@(posedge clk) disable iff (!arst_n)
		((ans_q | quit_q) & ~valid_q) == '0)
		else $error("flag set on a free slot");
`endif

endmodule

// File: hdl/hbw_emit.sv
`timescale 1ns / 1ps

module hbw_emit
	import hbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             bat_valid,
	output logic             bat_ready,
	input  bat_t             bat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	logic             hold_q;
	bat_t             bq_q;
	logic             mtv_q;
	logic             mtl_q;
	logic [OUT_W-1:0] mtd_q;
	logic             load;
	logic             any_req;
	logic [IDX_W-1:0] req_idx;

	always_comb begin
		any_req = 1'b0;
		req_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (bq_q.mask[i]) begin
				any_req = 1'b1;
				req_idx = IDX_W'(i);
			end
		end
	end

	assign bat_ready = !hold_q;
	assign load      = hold_q && (!mtv_q || m_tready);
	assign m_tvalid  = mtv_q;
	assign m_tdata   = mtd_q;
	assign m_tlast   = mtl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			mtv_q  <= 1'b0;
		end else begin
			if (bat_valid && !hold_q) begin
				hold_q <= 1'b1;
			end else if (load && !any_req) begin
				hold_q <= 1'b0;
			end
			if (load) begin
				mtv_q <= 1'b1;
			end else if (m_tready) begin
				mtv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bat_valid && !hold_q) begin
			bq_q <= bat;
		end else if (load) begin
			if (any_req) begin
				mtd_q <= {bq_q.deadline, SLOT_W'(req_idx), K_HB_REQ};
				mtl_q <= 1'b0;
				bq_q.mask[req_idx] <= 1'b0;
			end else begin
				mtd_q <= {bq_q.deadline, bq_q.slot, bq_q.kind};
				mtl_q <= 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !any_req) |=> !hold_q)
		else $error("batch held after final transfer loaded");
`endif

endmodule

// File: hdl/multi_slot_heartbeat_watchdog_core.sv
`timescale 1ns / 1ps

// Heartbeat watchdog over a table of 16 client slots. Each input transfer is a
// command (tick, register, unregister, answer, prequit, age reset); each command
// produces one or more result transfers, the final one marked by m_tlast, all
// carrying the nearest deadline after the command. A command is decoded, then a
// scan reads every slot of the table through the single read port of the slot
// RAM, ages each slot on a tick (or the named slot on an age reset) and tracks
// the minimum deadline, then hands the results to the output stage. Results
// then leave at one transfer per cycle while m_tready is high, while the next
// command is already scanned. Up to two commands wait in the input queue. After
// a fatal result every command answers halted until reset.
module multi_slot_heartbeat_watchdog_core
	import hbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // cmd, slot, elapsed_ms, period_ms, initial_delay_ms, pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // kind, slot_res, next_deadline_ms
	output logic             m_tlast
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	logic bat_valid;
	logic bat_ready;
	bat_t bat;

	hbw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	hbw_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.bat_valid (bat_valid),
		.bat_ready (bat_ready),
		.bat       (bat)
	);

	hbw_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.bat_valid (bat_valid),
		.bat_ready (bat_ready),
		.bat       (bat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
